// ===== rtl/rrxs_pkg.sv =====
`default_nettype none

package rrxs_pkg;

    // Bank size and field widths
    localparam int NUM_WORDS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int KIND_W        = 2;
    localparam int LOAD_IDX_W    = 4;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RAW   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RANGE = 2'd2;

    // xorshift32 shift amounts
    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    // Remainder steps, one quotient bit each
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [LOAD_IDX_W-1:0]   load_index;
        logic [WORD_W-1:0]       load_value;
        logic signed [WORD_W-1:0] range_low;
        logic signed [WORD_W-1:0] range_high;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]        raw_word;
        logic signed [WORD_W-1:0] ranged_value;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic update;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_draw;
        logic is_range;
        logic div_last;
        logic out_free;
    } t_sts;

    function automatic logic [WORD_W-1:0] xs_next(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = x ^ (x << SHIFT_A);
        b = a ^ (a >> SHIFT_B);
        return b ^ (b << SHIFT_C);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rrxs_ram.sv =====
`default_nettype none

module rrxs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/rrxs_datapath.sv =====
`default_nettype none

module rrxs_datapath #(
    parameter int NUM_WORDS = rrxs_pkg::NUM_WORDS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rrxs_pkg::t_in_item  i_in_item,
    input  wire logic                i_out_stall,
    input  wire rrxs_pkg::t_cmd      i_cmd,
    output rrxs_pkg::t_sts           o_sts,
    output logic                     o_out_valid,
    output rrxs_pkg::t_out_item      o_out_item
);

    localparam int IDX_W = $clog2(NUM_WORDS);
    localparam int W     = rrxs_pkg::WORD_W;
    localparam int CW    = rrxs_pkg::DIV_CNT_W;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_range;
    logic [W-1:0]     r_lo;
    logic [W-1:0]     r_span;
    logic [W-1:0]     r_word;
    logic [W-1:0]     r_dvd;
    logic [W-1:0]     r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_out_valid;
    rrxs_pkg::t_out_item r_out_item;

    logic             load_ok;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [W-1:0]     wr_data;
    logic [W-1:0]     rd_data;
    logic [W-1:0]     xs_word;
    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic [W-1:0]     n_rem;
    logic [W-1:0]     rem_fin;
    logic             out_free;

    // Decode load items
    assign load_ok = (i_in_item.kind == rrxs_pkg::KIND_LOAD)
                   && (32'(i_in_item.load_index) < 32'(NUM_WORDS));

    // Share the write port between loads and draw updates
    assign xs_word = rrxs_pkg::xs_next(rd_data);
    assign wr_en   = (i_cmd.accept && load_ok) || i_cmd.update;
    assign wr_addr = i_cmd.update ? r_idx : IDX_W'(i_in_item.load_index);
    assign wr_data = i_cmd.update ? xs_word : i_in_item.load_value;

    rrxs_ram #(
        .WIDTH (W),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    // Advance the round robin index
    assign n_idx = (r_idx == IDX_W'(NUM_WORDS - 1)) ? '0 : r_idx + 1'b1;

    // One restoring remainder step
    assign shifted = {r_rem, r_dvd[W-1]};
    assign diff    = shifted - {1'b0, r_span};
    assign n_rem   = diff[W] ? shifted[W-1:0] : diff[W-1:0];
    assign rem_fin = (r_span == '0) ? r_word : r_rem;

    assign out_free = !r_out_valid || !i_out_stall;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_idx <= n_idx;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_range <= (i_in_item.kind == rrxs_pkg::KIND_RANGE);
            r_lo    <= i_in_item.range_low;
            r_span  <= i_in_item.range_high - i_in_item.range_low + 1'b1;
        end
        if (i_cmd.update) begin
            r_word <= xs_word;
            r_dvd  <= xs_word;
            r_rem  <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_item.raw_word     <= r_word;
            r_out_item.ranged_value <= r_range ? r_lo + rem_fin : '0;
        end
    end

    assign o_sts.in_draw  = (i_in_item.kind == rrxs_pkg::KIND_RAW)
                          || (i_in_item.kind == rrxs_pkg::KIND_RANGE);
    assign o_sts.is_range = r_range;
    assign o_sts.div_last = (r_cnt == CW'(rrxs_pkg::DIV_STEPS - 1));
    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out_item;

    // Never overwrite a result that is still waiting
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result register overwritten while stalled");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && r_span != '0) |-> (r_rem < r_span))
        else $error("partial remainder out of range");

    // Round robin index stays inside the bank
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> (32'(r_idx) < 32'(NUM_WORDS)))
        else $error("word index out of range");

    // A draw update never coincides with a load write
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.update && i_cmd.accept))
        else $error("update and accept in the same cycle");

endmodule

`default_nettype wire

// ===== rtl/rrxs_ctrl.sv =====
`default_nettype none

module rrxs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire rrxs_pkg::t_sts i_sts,
    output logic                o_in_stall,
    output rrxs_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sequence one draw at a time
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_sts.in_draw) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.update = 1'b1;
                n_state = i_sts.is_range ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // A range draw always passes through the remainder loop
    a_range_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && i_sts.is_range) |=> (r_state == ST_DIV))
        else $error("range draw skipped remainder");

    // Results are only loaded at the end of a draw
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == ST_IDLE))
        else $error("result loaded outside of done");

    // A draw acceptance always starts the read
    a_draw_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.in_draw) |=> (r_state == ST_READ))
        else $error("draw accepted without read");

endmodule

`default_nettype wire

// ===== rtl/round_robin_xorshift32_rng_unit.sv =====
`default_nettype none

// Channel  Valid         Stall         Payload
// input    i_in_valid    o_in_stall    i_in_item  (rrxs_pkg::t_in_item)
// output   o_out_valid   i_out_stall   o_out_item (rrxs_pkg::t_out_item)
//
// A load writes its word at the accepting edge.
// A raw draw passes through accept, bank read and update, and result load;
// a ranged draw adds the 32-step restoring remainder loop before the load.
// Reset clears the word index and the result valid; bank words are
// undefined until loaded. A stalled result holds in the output register
// while the next item is accepted; a finished draw waits in ST_DONE for space.

module round_robin_xorshift32_rng_unit #(
    parameter int NUM_WORDS = rrxs_pkg::NUM_WORDS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire rrxs_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output rrxs_pkg::t_out_item      o_out_item
);

    rrxs_pkg::t_cmd cmd;
    rrxs_pkg::t_sts sts;

    rrxs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    rrxs_datapath #(
        .NUM_WORDS (NUM_WORDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
